/* rtl/htfc_pkg.sv */
`default_nettype none

package htfc_pkg;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // byte positions inside the 8-byte response frame
  localparam logic [2:0] PosHumHi  = 3'd2;
  localparam logic [2:0] PosTempLo = 3'd5;
  localparam logic [2:0] PosCrcLo  = 3'd6;
  localparam logic [2:0] PosLast   = 3'd7;

  localparam int unsigned StoreDepth = 5;

  localparam logic signed [17:0] TempSat = 18'sd33767;
  localparam logic signed [17:0] HumMax  = 18'sd1000;

  localparam logic signed [16:0] TempHighReset = 17'sd33767;
  localparam logic signed [16:0] TempLowReset  = -17'sd33767;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

  typedef enum logic [2:0] {
    CfgTempOffset = 3'd0,
    CfgHumOffset  = 3'd1,
    CfgTempHigh   = 3'd2,
    CfgTempLow    = 3'd3,
    CfgAlarmEn    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AlarmNone = 2'd0,
    AlarmHigh = 2'd1,
    AlarmLow  = 2'd2
  } alarm_e;

  typedef struct packed {
    logic signed [10:0] temp_offset;
    logic signed [10:0] hum_offset;
    logic signed [16:0] temp_high;
    logic signed [16:0] temp_low;
    logic               alarm_en;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        raw_hum;
    logic [15:0]        raw_temp;
    logic signed [16:0] temp_signed;
    logic [15:0]        crc_calc;
    logic [15:0]        crc_rx;
  } frame_t;

  typedef struct packed {
    logic               status;
    logic [9:0]         hum;
    logic signed [16:0] temp;
    logic [15:0]        raw_hum;
    logic [15:0]        raw_temp;
    alarm_e             alarm;
  } res_t;

  // crc-16 modbus, one byte folded in, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/htfc_calc.sv */
`default_nettype none

module htfc_calc (
  input  htfc_pkg::frame_t frame_i,
  input  htfc_pkg::cfg_t   cfg_i,
  output htfc_pkg::res_t   res_o
);
  import htfc_pkg::*;

  logic signed [17:0] hum_sum;
  logic signed [17:0] temp_sum;
  logic [9:0]         hum_clamp;
  logic signed [16:0] temp_clamp;
  alarm_e             alarm;

  assign hum_sum  = $signed({2'b00, frame_i.raw_hum}) + 18'(cfg_i.hum_offset);
  assign temp_sum = 18'(frame_i.temp_signed) + 18'(cfg_i.temp_offset);

  always_comb begin
    priority if (hum_sum < 18'sd0) begin
      hum_clamp = '0;
    end else if (hum_sum > HumMax) begin
      hum_clamp = HumMax[9:0];
    end else begin
      hum_clamp = hum_sum[9:0];
    end
  end

  always_comb begin
    priority if (temp_sum > TempSat) begin
      temp_clamp = TempSat[16:0];
    end else if (temp_sum < -TempSat) begin
      temp_clamp = 17'(-TempSat);
    end else begin
      temp_clamp = temp_sum[16:0];
    end
  end

  // high limit wins over low limit
  always_comb begin
    priority if (!cfg_i.alarm_en) begin
      alarm = AlarmNone;
    end else if (temp_clamp > cfg_i.temp_high) begin
      alarm = AlarmHigh;
    end else if (temp_clamp < cfg_i.temp_low) begin
      alarm = AlarmLow;
    end else begin
      alarm = AlarmNone;
    end
  end

  always_comb begin
    if (frame_i.crc_rx != frame_i.crc_calc) begin
      res_o        = '0;
      res_o.status = StatusCrcErr;
      res_o.alarm  = AlarmNone;
    end else begin
      res_o.status   = StatusOk;
      res_o.hum      = hum_clamp;
      res_o.temp     = temp_clamp;
      res_o.raw_hum  = frame_i.raw_hum;
      res_o.raw_temp = frame_i.raw_temp;
      res_o.alarm    = alarm;
    end
  end

endmodule

`default_nettype wire

/* rtl/humidity_temp_frame_checker_core.sv */
`default_nettype none

// channel   dir  payload
// s_axis    in   tdata[7:0] rx_byte, tuser frame_start
// m_axis    out  tdata[63:0] fields below, tuser status_code
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// one byte accepted per cycle unless a finished frame is stalled; a byte waits in the input
// register, and the eighth byte of a frame loads the result register as it leaves it.
// the result register is the only output stage; a byte that ends a frame waits
// in the input register while an earlier result is still not taken.
// reset clears position, crc and both valid flags; the frame byte store is not reset.
module humidity_temp_frame_checker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [9:0] humidity_tenths, [26:10] temperature_tenths,
                                           // [42:27] raw_humidity, [58:43] raw_temperature,
                                           // [60:59] alarm_code, [63:61] zero
  output logic             m_axis_tuser,   // [0] status_code
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);
  import htfc_pkg::*;

  cfg_t        cfg_q;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [15:0] crc_q, crc_d, crc_base;
  logic [2:0]  store_idx;
  logic [7:0]  store_q [StoreDepth];
  logic signed [16:0] temp_sm_q;
  logic [15:0] rt_now;

  logic        is_last;
  logic        adv;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_user_q;

  frame_t      frame;
  res_t        res;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_offset <= '0;
      cfg_q.hum_offset  <= '0;
      cfg_q.temp_high   <= TempHighReset;
      cfg_q.temp_low    <= TempLowReset;
      cfg_q.alarm_en    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTempOffset: cfg_q.temp_offset <= cfg_data_i[10:0];
        CfgHumOffset:  cfg_q.hum_offset  <= cfg_data_i[10:0];
        CfgTempHigh:   cfg_q.temp_high   <= cfg_data_i;
        CfgTempLow:    cfg_q.temp_low    <= cfg_data_i;
        CfgAlarmEn:    cfg_q.alarm_en    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame position and crc as seen by the byte in the input register
  assign pos_eff  = in_start_q ? 3'd0 : pos_q;
  assign crc_base = in_start_q ? CrcInit : crc_q;
  assign is_last  = (pos_eff == PosLast);
  assign adv      = in_valid_q && (!is_last || !out_valid_q || m_axis_tready);

  assign s_axis_tready = !in_valid_q || adv;

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (adv) begin
      if (is_last) begin
        pos_d = 3'd0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_eff + 3'd1;
        crc_d = (pos_eff < PosCrcLo) ? crc_byte(crc_base, in_byte_q) : crc_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      crc_q      <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // bytes 2..6 kept for the end of frame
  assign store_idx = pos_eff - PosHumHi;
  assign rt_now    = {store_q[2], in_byte_q};

  always_ff @(posedge clk_i) begin
    if (adv && !is_last && pos_eff >= PosHumHi) begin
      store_q[store_idx] <= in_byte_q;
    end
    // sign-magnitude to two's complement ahead of the last byte
    if (adv && pos_eff == PosTempLo) begin
      temp_sm_q <= rt_now[15] ? -$signed({2'b00, rt_now[14:0]})
                              :  $signed({2'b00, rt_now[14:0]});
    end
  end

  assign frame.raw_hum     = {store_q[0], store_q[1]};
  assign frame.raw_temp    = {store_q[2], store_q[3]};
  assign frame.temp_signed = temp_sm_q;
  assign frame.crc_calc    = crc_base;
  assign frame.crc_rx      = {in_byte_q, store_q[4]};

  htfc_calc u_calc (
    .frame_i (frame),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && is_last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_last) begin
      out_data_q <= {3'b000, res.alarm, res.raw_temp, res.raw_hum, res.temp, res.hum};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
